// File: src/spi_eeprom_master_core_defines.svh
// Assertion macros for the SPI EEPROM master.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef SPI_EEPROM_MASTER_CORE_DEFINES_SVH
`define SPI_EEPROM_MASTER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define SEEM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("seem: implication check failed");

// Next-cycle implication, checked out of reset
`define SEEM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("seem: next-cycle check failed");

`endif

// File: src/seem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package seem_pkg;

  // Widths of the transfer fields and internal state
  localparam int ADDR_BITS = 16;
  localparam int ADDR_W    = 16;
  localparam int DATA_W    = 8;
  localparam int TX_W      = 32;
  localparam int BC_W      = 6;

  // Address mask and the left-aligned positions of address and data
  localparam logic [TX_W-1:0] ADDR_MASK = TX_W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam int ADDR_SHIFT = TX_W - ADDR_BITS;
  localparam int DATA_SHIFT = 24 - ADDR_BITS;

  // EEPROM command bytes
  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_WRITE = 8'h02;
  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_RDSR  = 8'h05;

  // Transaction lengths as bits shifted per phase
  localparam logic [BC_W-1:0] LEN_CMD    = BC_W'(8);
  localparam logic [BC_W-1:0] LEN_ADDR   = BC_W'(16 + ADDR_BITS);
  localparam logic [BC_W-1:0] LEN_STATUS = BC_W'(16);

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_READ   = 2'd1,
    OP_WRITE  = 2'd2,
    OP_STATUS = 2'd3
  } seem_op_t;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_WREN       = 4'd1,
    PH_WRITE      = 4'd2,
    PH_POLL       = 4'd3,
    PH_READ       = 4'd4,
    PH_STATUS     = 4'd5,
    PH_HOLD_WREN  = 4'd6,
    PH_DESEL_WREN = 4'd7,
    PH_HOLD_POLL  = 4'd8,
    PH_DESEL_POLL = 4'd9,
    PH_ENDING     = 4'd10
  } seem_phase_t;

  typedef struct packed {
    seem_op_t           opcode;
    logic [ADDR_W-1:0]  address;
    logic [DATA_W-1:0]  write_data;
    logic               miso;
  } seem_item_t;

  typedef struct packed {
    logic               chip_select_n;
    logic               serial_clock;
    logic               mosi;
    logic               busy_res;
    logic               done_res;
    logic [DATA_W-1:0]  read_data;
    logic               rejected;
  } seem_res_t;

  // Command byte sent at the start of each shifting phase
  function automatic logic [7:0] phase_cmd(seem_phase_t p);
    logic [7:0] c;
    case (p)
      PH_WREN:  c = CMD_WREN;
      PH_WRITE: c = CMD_WRITE;
      PH_READ:  c = CMD_READ;
      default:  c = CMD_RDSR;
    endcase
    return c;
  endfunction

  // Number of bits shifted in each shifting phase
  function automatic logic [BC_W-1:0] phase_len(seem_phase_t p);
    logic [BC_W-1:0] n;
    case (p)
      PH_WREN:  n = LEN_CMD;
      PH_WRITE: n = LEN_ADDR;
      PH_READ:  n = LEN_ADDR;
      default:  n = LEN_STATUS;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// File: src/spi_eeprom_master_core.sv
// SPI EEPROM master (25xx family, SPI mode 3, MSB first). Each input transfer is
// either a half-bit tick, which moves the SPI clock by half a period and carries
// the sampled MISO bit, or a request (read byte, write byte, read status); a
// request that arrives while busy is dropped and flagged as rejected. Every input
// transfer produces exactly one result transfer holding the pin levels, status
// and, on completion, the byte read. The block takes one item per clock cycle
// while the output is not stalled: controller state is updated in a single pass
// from the accepted item, the result lands in one output register, and input is
// accepted whenever that register is empty or being drained in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "spi_eeprom_master_core_defines.svh"

module spi_eeprom_master_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_write_data,
  input  wire logic        in_miso,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_chip_select_n,
  output logic             out_serial_clock,
  output logic             out_mosi,
  output logic             out_busy_res,
  output logic             out_done_res,
  output logic [7:0]       out_read_data,
  output logic             out_rejected
);
  import seem_pkg::*;

  seem_item_t item;
  seem_res_t  res;
  seem_res_t  res_r;
  logic       out_valid_r;
  logic       accept;

  // Input handshake
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign item.opcode     = seem_op_t'(in_opcode);
  assign item.address    = in_address;
  assign item.write_data = in_write_data;
  assign item.miso       = in_miso;

  seem_fsm u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (accept),
    .item_i (item),
    .res_o  (res)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_chip_select_n = res_r.chip_select_n;
  assign out_serial_clock  = res_r.serial_clock;
  assign out_mosi          = res_r.mosi;
  assign out_busy_res      = res_r.busy_res;
  assign out_done_res      = res_r.done_res;
  assign out_read_data     = res_r.read_data;
  assign out_rejected      = res_r.rejected;

  // Completion is reported on the ending step, deselected and never while still busy
  `SEEM_ASSERT_IMP(a_done_idle, out_valid_r && res_r.done_res, !res_r.busy_res && res_r.chip_select_n)
  // Read data is zero unless a request completes
  `SEEM_ASSERT_IMP(a_rdata_zero, out_valid_r && !res_r.done_res, res_r.read_data == 8'h00)
  // A dropped request leaves the controller busy
  `SEEM_ASSERT_IMP(a_reject_busy, out_valid_r && res_r.rejected, res_r.busy_res && !res_r.done_res)
  // A stalled result blocks new input
  `SEEM_ASSERT_IMP(a_stall_blocks, out_valid_r && !out_ready, !in_ready)

endmodule

`default_nettype wire

// File: src/seem_fsm.sv
`timescale 1ns / 1ps
`default_nettype none

module seem_fsm (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_i,
  input  wire seem_pkg::seem_item_t item_i,
  output seem_pkg::seem_res_t    res_o
);
  import seem_pkg::*;

  seem_phase_t       phase_r, phase_nxt;
  logic [BC_W-1:0]   bc_r, bc_nxt, bc_inc;
  logic [TX_W-1:0]   tx_r, tx_nxt;
  logic [DATA_W-1:0] rx_r, rx_nxt;
  logic              half_r, half_nxt;
  logic              mosi_r, mosi_nxt;
  logic [TX_W-1:0]   addr_tx, data_tx;
  logic [7:0]        cmd_sh;
  logic              active, done, rejected;
  logic [DATA_W-1:0] rdata;

  // Left-aligned address (and data byte for writes)
  assign addr_tx = (TX_W'(item_i.address) & ADDR_MASK) << ADDR_SHIFT;
  assign data_tx = TX_W'(item_i.write_data) << DATA_SHIFT;

  // Phases that drive the SPI clock
  assign active = phase_r inside {[PH_WREN:PH_STATUS]};

  // Next state for one item
  always_comb begin
    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    tx_nxt    = tx_r;
    rx_nxt    = rx_r;
    half_nxt  = half_r;
    mosi_nxt  = mosi_r;
    done      = 1'b0;
    rejected  = 1'b0;
    rdata     = '0;
    bc_inc    = bc_r + BC_W'(1);
    cmd_sh    = phase_cmd(phase_r) << bc_r[2:0];
    if (item_i.opcode != OP_TICK) begin
      // Request: start when idle, else drop it
      if (phase_r != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        rx_nxt   = '0;
        bc_nxt   = '0;
        half_nxt = 1'b1;
        case (item_i.opcode)
          OP_READ: begin
            tx_nxt    = addr_tx;
            phase_nxt = PH_READ;
          end
          OP_WRITE: begin
            tx_nxt    = addr_tx | data_tx;
            phase_nxt = PH_WREN;
          end
          default: begin
            tx_nxt    = '0;
            phase_nxt = PH_STATUS;
          end
        endcase
      end
    end else if (active) begin
      if (half_r) begin
        // Falling edge: drive the next data bit
        half_nxt = 1'b0;
        mosi_nxt = (bc_r < LEN_CMD) ? cmd_sh[7] : tx_r[TX_W-1];
      end else begin
        // Rising edge: sample MISO, advance the bit count
        half_nxt = 1'b1;
        rx_nxt   = {rx_r[DATA_W-2:0], item_i.miso};
        if (bc_r >= LEN_CMD) begin
          tx_nxt = tx_r << 1;
        end
        bc_nxt = bc_inc;
        if (bc_inc >= phase_len(phase_r)) begin
          case (phase_r)
            PH_WREN:  phase_nxt = PH_HOLD_WREN;
            PH_WRITE: phase_nxt = PH_HOLD_POLL;
            PH_POLL:  phase_nxt = (rx_nxt == '0) ? PH_ENDING : PH_HOLD_POLL;
            default:  phase_nxt = PH_ENDING;
          endcase
        end
      end
    end else begin
      // Hold, deselect and completion steps
      case (phase_r)
        PH_HOLD_WREN:  phase_nxt = PH_DESEL_WREN;
        PH_DESEL_WREN: begin
          phase_nxt = PH_WRITE;
          bc_nxt    = '0;
          half_nxt  = 1'b1;
        end
        PH_HOLD_POLL:  phase_nxt = PH_DESEL_POLL;
        PH_DESEL_POLL: begin
          phase_nxt = PH_POLL;
          rx_nxt    = '0;
          bc_nxt    = '0;
          half_nxt  = 1'b1;
        end
        PH_ENDING: begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
          rdata     = rx_r;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Pin levels and status after this item
  always_comb begin
    res_o.chip_select_n = phase_nxt inside {PH_IDLE, PH_DESEL_WREN, PH_DESEL_POLL};
    res_o.serial_clock  = (phase_nxt inside {[PH_WREN:PH_STATUS]}) ? half_nxt : 1'b1;
    res_o.mosi          = mosi_nxt;
    res_o.busy_res      = (phase_nxt != PH_IDLE);
    res_o.done_res      = done;
    res_o.read_data     = rdata;
    res_o.rejected      = rejected;
  end

  // State registers, advanced once per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bc_r    <= '0;
      tx_r    <= '0;
      rx_r    <= '0;
      half_r  <= 1'b1;
      mosi_r  <= 1'b1;
    end else if (step_i) begin
      phase_r <= phase_nxt;
      bc_r    <= bc_nxt;
      tx_r    <= tx_nxt;
      rx_r    <= rx_nxt;
      half_r  <= half_nxt;
      mosi_r  <= mosi_nxt;
    end
  end

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import seem_pkg::*;

  // Tracks the controller state and works out the pin levels and status
  // expected for every accepted transfer, then checks results in order.
  class spi_pin_predictor;
    seem_phase_t phase;
    logic [5:0]  bit_count;
    logic [31:0] tx_shift;
    logic [7:0]  rx_shift;
    logic        clock_half;
    logic        mosi_level;
    seem_res_t   expected_pins[$];
    int          fail_count;

    function void power_up();
      phase      = PH_IDLE;
      bit_count  = '0;
      tx_shift   = '0;
      rx_shift   = '0;
      clock_half = 1'b1;
      mosi_level = 1'b1;
      fail_count = 0;
    endfunction

    function bit shifting(seem_phase_t p);
      return p >= PH_WREN && p <= PH_STATUS;
    endfunction

    function logic [7:0] cmd_for(seem_phase_t p);
      case (p)
        PH_WREN:  return CMD_WREN;
        PH_WRITE: return CMD_WRITE;
        PH_READ:  return CMD_READ;
        default:  return CMD_RDSR;
      endcase
    endfunction

    // bits shifted in one shifting phase: command, address, data or status
    function logic [5:0] periods_in(seem_phase_t p);
      case (p)
        PH_WREN:           return 6'd8;
        PH_WRITE, PH_READ: return 6'(16 + ADDR_BITS);
        default:           return 6'd16;
      endcase
    endfunction

    function void open_frame(seem_phase_t p);
      phase      = p;
      bit_count  = '0;
      clock_half = 1'b1;
    endfunction

    function void close_frame();
      case (phase)
        PH_WREN:  phase = PH_HOLD_WREN;
        PH_WRITE: phase = PH_HOLD_POLL;
        PH_POLL:  phase = (rx_shift == 8'h00) ? PH_ENDING : PH_HOLD_POLL;
        default:  phase = PH_ENDING;
      endcase
    endfunction

    // Advance the state by one accepted input transfer
    function void take_item(seem_item_t it);
      seem_res_t   r;
      logic [31:0] addr;
      logic [7:0]  c;
      r    = '0;
      addr = 32'(it.address) & ADDR_MASK;
      if (it.opcode != OP_TICK) begin
        if (phase != PH_IDLE) begin
          r.rejected = 1'b1;
        end else begin
          rx_shift = '0;
          case (it.opcode)
            OP_READ: begin
              tx_shift = addr << (32 - ADDR_BITS);
              open_frame(PH_READ);
            end
            OP_WRITE: begin
              tx_shift = (addr << (32 - ADDR_BITS)) |
                         (32'(it.write_data) << (24 - ADDR_BITS));
              open_frame(PH_WREN);
            end
            default: begin
              tx_shift = '0;
              open_frame(PH_STATUS);
            end
          endcase
        end
      end else if (shifting(phase)) begin
        if (clock_half) begin
          // falling edge: drive the next MOSI bit
          clock_half = 1'b0;
          if (bit_count < 6'd8) begin
            c          = cmd_for(phase);
            mosi_level = c[3'(7 - bit_count)];
          end else begin
            mosi_level = tx_shift[31];
          end
        end else begin
          // rising edge: sample MISO
          clock_half = 1'b1;
          rx_shift   = {rx_shift[6:0], it.miso};
          if (bit_count >= 6'd8) tx_shift = tx_shift << 1;
          bit_count = bit_count + 6'd1;
          if (bit_count >= periods_in(phase)) close_frame();
        end
      end else begin
        case (phase)
          PH_HOLD_WREN:  phase = PH_DESEL_WREN;
          PH_DESEL_WREN: open_frame(PH_WRITE);
          PH_HOLD_POLL:  phase = PH_DESEL_POLL;
          PH_DESEL_POLL: begin
            rx_shift = '0;
            open_frame(PH_POLL);
          end
          PH_ENDING: begin
            phase       = PH_IDLE;
            r.done_res  = 1'b1;
            r.read_data = rx_shift;
          end
          default: ;
        endcase
      end
      r.chip_select_n = (phase == PH_IDLE || phase == PH_DESEL_WREN ||
                         phase == PH_DESEL_POLL);
      r.serial_clock  = shifting(phase) ? clock_half : 1'b1;
      r.mosi          = mosi_level;
      r.busy_res      = (phase != PH_IDLE);
      expected_pins.push_back(r);
    endfunction

    function void flag(string what, int unsigned want, int unsigned got_v);
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on %0s: expected 0x%0h, got 0x%0h", what, want, got_v);
    endfunction

    function void check_pins(seem_res_t got);
      seem_res_t want;
      if (expected_pins.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("result transfer with nothing expected: %p", got);
        return;
      end
      want = expected_pins.pop_front();
      if (got.chip_select_n !== want.chip_select_n)
        flag("chip_select_n", want.chip_select_n, got.chip_select_n);
      if (got.serial_clock !== want.serial_clock)
        flag("serial_clock", want.serial_clock, got.serial_clock);
      if (got.mosi !== want.mosi) flag("mosi", want.mosi, got.mosi);
      if (got.busy_res !== want.busy_res) flag("busy_res", want.busy_res, got.busy_res);
      if (got.done_res !== want.done_res) flag("done_res", want.done_res, got.done_res);
      if (got.read_data !== want.read_data)
        flag("read_data", want.read_data, got.read_data);
      if (got.rejected !== want.rejected) flag("rejected", want.rejected, got.rejected);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = '0;
  logic [15:0] in_address = '0;
  logic [7:0]  in_write_data = '0;
  logic        in_miso = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_chip_select_n;
  logic        out_serial_clock;
  logic        out_mosi;
  logic        out_busy_res;
  logic        out_done_res;
  logic [7:0]  out_read_data;
  logic        out_rejected;

  spi_pin_predictor sb;
  int burst_left = 0;
  int busy_items = 0;
  int stretch_left = 0;
  int ready_mode = 0;
  int beat = 0;

  spi_eeprom_master_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_address       (in_address),
    .in_write_data    (in_write_data),
    .in_miso          (in_miso),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_chip_select_n(out_chip_select_n),
    .out_serial_clock (out_serial_clock),
    .out_mosi         (out_mosi),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_read_data    (out_read_data),
    .out_rejected     (out_rejected)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver: stretches of always-ready, random stalls, or a fixed 2-of-3 beat
  always @(posedge clk) begin
    beat <= beat + 1;
    if (stretch_left == 0) begin
      ready_mode   <= $urandom_range(2);
      stretch_left <= $urandom_range(20, 200);
    end else begin
      stretch_left <= stretch_left - 1;
    end
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom);
      default: out_ready <= (beat % 3) != 0;
    endcase
  end

  // Result transfers are checked in order against the predictor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_pins('{chip_select_n: out_chip_select_n, serial_clock: out_serial_clock,
                      mosi: out_mosi, busy_res: out_busy_res, done_res: out_done_res,
                      read_data: out_read_data, rejected: out_rejected});
  end

  // Offer one input transfer, with a random gap at the start of most bursts
  task automatic send_item(input seem_op_t op, input logic [15:0] addr,
                           input logic [7:0] data, input logic bit_in);
    seem_item_t it;
    it = '{opcode: op, address: addr, write_data: data, miso: bit_in};
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_address    <= addr;
    in_write_data <= data;
    in_miso       <= bit_in;
    do @(posedge clk); while (!in_ready);
    sb.take_item(it);
  endtask

  // Issue one request and tick it through to completion.
  // MISO: 0 all zero, 1 all one (first two polls nonzero), else random.
  task automatic run_request(input seem_op_t op, input logic [15:0] addr,
                             input logic [7:0] data, input int miso_mode,
                             input int noise_pct);
    int   polls;
    logic m;
    polls = 0;
    send_item(op, addr, data, 1'($urandom));
    busy_items++;
    while (sb.phase != PH_IDLE) begin
      if ($urandom_range(99) < noise_pct) begin
        // request while busy, must be dropped
        send_item(seem_op_t'($urandom_range(1, 3)), 16'($urandom), 8'($urandom),
                  1'($urandom));
      end else begin
        if (sb.phase == PH_DESEL_POLL) polls++;
        if (sb.phase == PH_POLL)
          m = (miso_mode == 1 && polls <= 2) ||
              (miso_mode >= 2 && polls < 6 && $urandom_range(7) == 0);
        else if (miso_mode == 0)
          m = 1'b0;
        else if (miso_mode == 1)
          m = 1'b1;
        else
          m = 1'($urandom);
        send_item(OP_TICK, 16'($urandom), 8'($urandom), m);
        busy_items++;
      end
    end
  endtask

  initial begin
    seem_op_t    op;
    logic [15:0] addr;
    sb = new;
    sb.power_up();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle ticks, each request kind at the field extremes,
    // a write that keeps polling, and requests while busy
    send_item(OP_TICK, 16'hFFFF, 8'hFF, 1'b1);
    send_item(OP_TICK, 16'h0000, 8'h00, 1'b0);
    run_request(OP_STATUS, 16'h0000, 8'h00, 1, 0);
    run_request(OP_READ, 16'hFFFF, 8'h00, 1, 0);
    run_request(OP_READ, 16'h0000, 8'hFF, 0, 0);
    run_request(OP_WRITE, 16'hFFFF, 8'hFF, 1, 0);
    run_request(OP_WRITE, 16'h0000, 8'h00, 0, 0);
    run_request(OP_READ, 16'hA5C3, 8'h5A, 2, 30);
    run_request(OP_WRITE, 16'h5A3C, 8'hA5, 2, 30);
    run_request(OP_STATUS, 16'h1234, 8'h81, 2, 30);

    // random requests with random content, sprinkled with idle ticks
    while (busy_items < 1750) begin
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(1, 3))
          send_item(OP_TICK, 16'($urandom), 8'($urandom), 1'($urandom));
      op = seem_op_t'($urandom_range(1, 3));
      case ($urandom_range(7))
        0:       addr = 16'h0000;
        1:       addr = 16'hFFFF;
        default: addr = 16'($urandom);
      endcase
      run_request(op, addr, 8'($urandom), $urandom_range(0, 5),
                  ($urandom_range(2) == 0) ? 5 : 0);
    end

    in_valid <= 1'b0;
    while (sb.expected_pins.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.fail_count == 0 && sb.expected_pins.size() == 0) begin
      $display("spi_eeprom_master_core regression: pass");
    end else begin
      $display("spi_eeprom_master_core regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("spi_eeprom_master_core regression: fail");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/seem_pkg.sv
src/seem_fsm.sv
src/spi_eeprom_master_core.sv
tb/testbench.sv
